// ===== rtl/dcs_pkg.sv =====
// Shared types and constants for the duplicate-free coordinate stack.
// Used by the controller, the datapath and the top level; depends on nothing.
package dcs_pkg;

  // Default grid size
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int COORD_IN_W  = 16;
  localparam int COORD_OUT_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LIMIT = 1'd1;

  // Reset value of both limit registers
  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 7'd64;

  // Request kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Coordinate reported for a push or an empty pop
  localparam logic signed [COORD_OUT_W-1:0] COORD_NONE = -7'sd1;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic read;
    logic update;
  } dcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dcs_sts_t;

endpackage

// ===== rtl/dcs_if.sv =====
// Request and response channel interfaces of the coordinate stack.
// Depends on dcs_pkg for the field widths.
interface dcs_req_if import dcs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [COORD_IN_W-1:0]  in_row;
  logic signed [COORD_IN_W-1:0]  in_col;

  modport source (output valid, kind, in_row, in_col, input ready);
  modport sink   (input valid, kind, in_row, in_col, output ready);
endinterface

interface dcs_rsp_if import dcs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic signed [COORD_OUT_W-1:0] out_row;
  logic signed [COORD_OUT_W-1:0] out_col;

  modport source (output valid, ok, out_row, out_col, input ready);
  modport sink   (input valid, ok, out_row, out_col, output ready);
endinterface

// ===== rtl/dcs_ctrl.sv =====
// Sequencing state machine of the coordinate stack: clearing pass, accept,
// memory read and update. Depends on dcs_pkg for the command and status types.
module dcs_ctrl import dcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dcs_cmd_t cmd,
  input  dcs_sts_t sts
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_UPDATE = 4'b1000
  } dcs_state_t;

  dcs_state_t state;
  dcs_state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // A captured request always moves on to the memory read
  a_capture_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_READ)
    else $error("captured request did not advance to read");

  // Never update while the output register still holds an untaken result
  a_update_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> sts.out_free)
    else $error("update issued with output register occupied");

  // Take requests only while idle
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("request accepted outside idle");

endmodule

// ===== rtl/dcs_datapath.sv =====
// Datapath of the coordinate stack: limit registers, mark bitmap memory,
// stack memory, fill count and output register. Depends on dcs_pkg.
module dcs_datapath import dcs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcs_cmd_t                      cmd,
  output dcs_sts_t                      sts,
  input  logic                          kind,
  input  logic signed [COORD_IN_W-1:0]  in_row,
  input  logic signed [COORD_IN_W-1:0]  in_col,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic signed [COORD_OUT_W-1:0] out_row,
  output logic signed [COORD_OUT_W-1:0] out_col
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int RB     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int FILL_W = $clog2(CELLS + 1);
  localparam int ENT_W  = RB + CB;

  logic [CFG_DATA_W-1:0] row_limit;
  logic [CFG_DATA_W-1:0] col_limit;

  logic              kind_q;
  logic              hit_q;
  logic [RB-1:0]     row_q;
  logic [CB-1:0]     col_q;
  logic [CELL_W-1:0] cell_q;

  logic [CELL_W-1:0] clr_addr;
  logic [FILL_W-1:0] fill_count;

  logic              mark_mem [CELLS];
  logic [ENT_W-1:0]  entry_mem [CELLS];
  logic              mark_rd;
  logic [ENT_W-1:0]  ent_rd;

  logic [COORD_IN_W-1:0] row_lim;
  logic [COORD_IN_W-1:0] col_lim;
  logic                  hit;
  logic [CELL_W-1:0]     cell_in;

  logic [RB-1:0]     ent_row;
  logic [CB-1:0]     ent_col;
  logic [CELL_W-1:0] pop_cell;
  logic [CELL_W-1:0] top_addr;
  logic              push_ok;
  logic              pop_ok;
  logic              push_done;
  logic              pop_done;
  logic              mark_we;
  logic              mark_val;
  logic [CELL_W-1:0] mark_addr;

  // Write limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= LIMIT_RESET;
      col_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_LIMIT: row_limit <= cfg_data;
        CFG_COL_LIMIT: col_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp limits to the grid and range-check the request
  always_comb begin
    row_lim = (COORD_IN_W'(row_limit) < COORD_IN_W'(MAX_ROWS)) ?
              COORD_IN_W'(row_limit) : COORD_IN_W'(MAX_ROWS);
    col_lim = (COORD_IN_W'(col_limit) < COORD_IN_W'(MAX_COLS)) ?
              COORD_IN_W'(col_limit) : COORD_IN_W'(MAX_COLS);
    hit     = !in_row[COORD_IN_W-1] && !in_col[COORD_IN_W-1] &&
              ($unsigned(in_row) < row_lim) && ($unsigned(in_col) < col_lim);
    cell_in = CELL_W'(in_row[RB-1:0]) * CELL_W'(MAX_COLS) + CELL_W'(in_col[CB-1:0]);
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      hit_q  <= hit;
      row_q  <= in_row[RB-1:0];
      col_q  <= in_col[CB-1:0];
      cell_q <= cell_in;
    end
  end

  // Advance the clearing pass over the bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !sts.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Decide the update
  always_comb begin
    ent_row   = ent_rd[ENT_W-1:CB];
    ent_col   = ent_rd[CB-1:0];
    pop_cell  = CELL_W'(ent_row) * CELL_W'(MAX_COLS) + CELL_W'(ent_col);
    top_addr  = CELL_W'(fill_count - 1'b1);
    push_ok   = hit_q && !mark_rd && (fill_count < FILL_W'(CELLS));
    pop_ok    = fill_count != '0;
    push_done = cmd.update && (kind_q == KIND_PUSH) && push_ok;
    pop_done  = cmd.update && (kind_q == KIND_POP) && pop_ok;
    mark_we   = push_done || pop_done;
    mark_val  = push_done;
    mark_addr = push_done ? cell_q : pop_cell;
    sts.clear_last = clr_addr == CELL_W'(CELLS - 1);
    sts.out_free   = !out_valid || out_ready;
  end

  // Mark bitmap: clear, set on push, drop on pop, read before update
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mark_mem[clr_addr] <= 1'b0;
    end else if (mark_we) begin
      mark_mem[mark_addr] <= mark_val;
    end
    if (cmd.read) begin
      mark_rd <= mark_mem[cell_q];
    end
  end

  // Stack memory: write on push, read top before update
  always_ff @(posedge clk) begin
    if (push_done) begin
      entry_mem[fill_count[CELL_W-1:0]] <= {row_q, col_q};
    end
    if (cmd.read) begin
      ent_rd <= entry_mem[top_addr];
    end
  end

  // Track stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (push_done) begin
      fill_count <= fill_count + 1'b1;
    end else if (pop_done) begin
      fill_count <= fill_count - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (kind_q == KIND_PUSH) begin
        ok      <= push_ok;
        out_row <= COORD_NONE;
        out_col <= COORD_NONE;
      end else begin
        ok      <= pop_ok;
        out_row <= pop_ok ? COORD_OUT_W'(ent_row) : COORD_NONE;
        out_col <= pop_ok ? COORD_OUT_W'(ent_col) : COORD_NONE;
      end
    end
  end

  // Depth never passes the number of cells
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(CELLS))
    else $error("stack depth exceeds cell count");

  // A stored push grows the stack by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_done |=> fill_count == $past(fill_count) + 1'b1)
    else $error("stored push did not advance depth");

  // A pop on an empty stack reports no coordinate
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.update && (kind_q == KIND_POP) && (fill_count == '0)
    |=> !ok && (out_row == COORD_NONE) && (out_col == COORD_NONE))
    else $error("empty pop reported a coordinate");

endmodule

// ===== rtl/dedup_coordinate_stack.sv =====
// Top level of the duplicate-free coordinate stack.
// Depends on dcs_pkg, dcs_if, dcs_ctrl and dcs_datapath.
//
// A last-in first-out stack of grid coordinates that refuses duplicates,
// backed by one bitmap memory (a mark per cell) and one stack memory, each
// MAX_ROWS*MAX_COLS deep. Each request is accepted, then reads the mark
// bitmap and the stack top, then writes them back, at which point its result
// is loaded into the output register. A new request is taken only after the
// previous one has written back, since every request reads the memories
// before it writes them. A finished result waits in an output register
// while the next request is accepted; if that result is still untaken when
// the next one is ready to write back, the write-back holds until the
// output register frees up. After reset a clearing pass sweeps the bitmap
// one cell a cycle, during which no request is accepted; limit registers
// can be written at any time. Limits are clamped to the grid size.
module dedup_coordinate_stack import dcs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  dcs_req_if.sink               req,
  dcs_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dcs_cmd_t cmd;
  dcs_sts_t sts;

  // Sequence each request
  dcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hold memories, depth and result
  dcs_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (req.kind),
    .in_row    (req.in_row),
    .in_col    (req.in_col),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ok        (rsp.ok),
    .out_row   (rsp.out_row),
    .out_col   (rsp.out_col)
  );

endmodule
